// File: rtl/uvs_pkg.sv
package uvs_pkg;

    localparam int COUNT_BITS    = 8;
    localparam int FRAC_BITS     = 15;
    localparam int Q_BITS        = 33;
    localparam int DIV_PER_STAGE = 3;
    localparam int DIV_STAGES    = Q_BITS / DIV_PER_STAGE;
    localparam int CORDIC_STEPS  = 24;
    localparam int CORDIC_PER_STAGE = 2;
    localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam int NSTAGES       = 1 + DIV_STAGES + CORDIC_STAGES + 2;
    localparam int ROT_STAGE     = 1 + DIV_STAGES + CORDIC_STAGES;
    localparam int LAST_STAGE    = NSTAGES - 1;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
    };

    typedef enum logic {
        REG_STACK_COUNT = 1'b0,
        REG_SLICE_COUNT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] ring;
        logic [COUNT_BITS-1:0] seg;
        logic [COUNT_BITS-1:0] stacks;
        logic [COUNT_BITS-1:0] slices;
        logic [COUNT_BITS-1:0] rem_p;
        logic [COUNT_BITS-1:0] rem_t;
        logic [Q_BITS-1:0]     q_p;
        logic [Q_BITS-1:0]     q_t;
        logic [1:0]            quad_p;
        logic [1:0]            quad_t;
        logic signed [31:0]    x_p;
        logic signed [31:0]    y_p;
        logic signed [31:0]    z_p;
        logic signed [31:0]    x_t;
        logic signed [31:0]    y_t;
        logic signed [31:0]    z_t;
        logic signed [63:0]    prod_x;
        logic signed [63:0]    prod_z;
        logic [15:0]           nx;
        logic [15:0]           ny;
        logic [15:0]           nz;
        logic [16:0]           tex_u;
        logic [16:0]           tex_v;
        logic [15:0]           ca;
        logic [15:0]           cb;
        logic [15:0]           cc;
        logic [15:0]           cd;
        logic                  qv;
    } item_t;

    // Clamp the indices and snapshot the effective counts.
    function automatic item_t capture(logic [COUNT_BITS-1:0] ring_in,
                                      logic [COUNT_BITS-1:0] seg_in,
                                      logic [COUNT_BITS-1:0] stack_cfg,
                                      logic [COUNT_BITS-1:0] slice_cfg);
        item_t it;
        logic [COUNT_BITS-1:0] st;
        logic [COUNT_BITS-1:0] sl;
        it = '0;
        st = (stack_cfg == '0) ? COUNT_BITS'(1) : stack_cfg;
        sl = (slice_cfg == '0) ? COUNT_BITS'(1) : slice_cfg;
        it.stacks = st;
        it.slices = sl;
        it.ring   = (ring_in > st) ? st : ring_in;
        it.seg    = (seg_in > sl) ? sl : seg_in;
        return it;
    endfunction

    function automatic item_t corner_calc(item_t it);
        item_t o;
        logic [16:0] a;
        logic [16:0] b;
        o = it;
        a = {9'd0, it.ring} * ({9'd0, it.slices} + 17'd1) + {9'd0, it.seg};
        b = a + {9'd0, it.slices} + 17'd1;
        o.qv = (it.ring < it.stacks) && (it.seg < it.slices);
        if (o.qv)
        begin
            o.ca = a[15:0];
            o.cb = b[15:0];
            o.cc = b[15:0] + 16'd1;
            o.cd = a[15:0] + 16'd1;
        end
        else
        begin
            o.ca = '0;
            o.cb = '0;
            o.cc = '0;
            o.cd = '0;
        end
        return o;
    endfunction

    // Restoring division of index * 2^32 by the count, a few quotient bits per stage.
    function automatic item_t div_stage(item_t it, int k);
        item_t o;
        int j;
        logic [COUNT_BITS:0] tp;
        logic [COUNT_BITS:0] tt;
        o = it;
        for (int m = 0; m < DIV_PER_STAGE; m++)
        begin
            j  = Q_BITS - 1 - DIV_PER_STAGE * (k - 1) - m;
            tp = (j == Q_BITS - 1) ? {1'b0, o.ring} : {o.rem_p, 1'b0};
            tt = (j == Q_BITS - 1) ? {1'b0, o.seg} : {o.rem_t, 1'b0};
            o.q_p[j] = (tp >= {1'b0, o.stacks});
            if (o.q_p[j])
                tp = tp - {1'b0, o.stacks};
            o.q_t[j] = (tt >= {1'b0, o.slices});
            if (o.q_t[j])
                tt = tt - {1'b0, o.slices};
            o.rem_p = tp[COUNT_BITS-1:0];
            o.rem_t = tt[COUNT_BITS-1:0];
        end
        return o;
    endfunction

    function automatic item_t cordic_init(item_t it);
        item_t o;
        logic [31:0] ph;
        logic [31:0] th;
        logic [33:0] su;
        logic [33:0] sv;
        o  = it;
        ph = it.q_p[32:1];
        th = it.q_t[31:0];
        o.quad_p = ph[31:30];
        o.quad_t = th[31:30];
        o.z_p = $signed({2'b00, ph[29:0]});
        o.z_t = $signed({2'b00, th[29:0]});
        o.x_p = CORDIC_GAIN;
        o.x_t = CORDIC_GAIN;
        o.y_p = '0;
        o.y_t = '0;
        su = {1'b0, it.q_t} + 34'd32768;
        sv = {1'b0, it.q_p} + 34'd32768;
        o.tex_u = su[32:16];
        o.tex_v = sv[32:16];
        return o;
    endfunction

    function automatic item_t cordic_stage(item_t it, int base);
        item_t o;
        int i;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        o = it;
        for (int m = 0; m < CORDIC_PER_STAGE; m++)
        begin
            i  = base + m;
            xs = o.x_p >>> i;
            ys = o.y_p >>> i;
            if (!o.z_p[31])
            begin
                o.x_p = o.x_p - ys;
                o.y_p = o.y_p + xs;
                o.z_p = o.z_p - ATAN_TURNS[i];
            end
            else
            begin
                o.x_p = o.x_p + ys;
                o.y_p = o.y_p - xs;
                o.z_p = o.z_p + ATAN_TURNS[i];
            end
            xs = o.x_t >>> i;
            ys = o.y_t >>> i;
            if (!o.z_t[31])
            begin
                o.x_t = o.x_t - ys;
                o.y_t = o.y_t + xs;
                o.z_t = o.z_t - ATAN_TURNS[i];
            end
            else
            begin
                o.x_t = o.x_t + ys;
                o.y_t = o.y_t - xs;
                o.z_t = o.z_t + ATAN_TURNS[i];
            end
        end
        return o;
    endfunction

    // Round half up by 2^s, then saturate to Q1.FRAC_BITS.
    function automatic logic [15:0] to_normal(logic signed [63:0] v, int s);
        logic signed [63:0] r;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< FRAC_BITS) - 64'sd1;
        lo = -(64'sd1 <<< FRAC_BITS);
        r  = (v + (64'sd1 <<< (s - 1))) >>> s;
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r[15:0];
    endfunction

    function automatic item_t rotate_mul(item_t it);
        item_t o;
        logic signed [31:0] cp;
        logic signed [31:0] sp;
        logic signed [31:0] ct;
        logic signed [31:0] st;
        o = it;
        case (it.quad_p)
            2'd0:    begin cp = it.x_p;  sp = it.y_p;  end
            2'd1:    begin cp = -it.y_p; sp = it.x_p;  end
            2'd2:    begin cp = -it.x_p; sp = -it.y_p; end
            default: begin cp = it.y_p;  sp = -it.x_p; end
        endcase
        case (it.quad_t)
            2'd0:    begin ct = it.x_t;  st = it.y_t;  end
            2'd1:    begin ct = -it.y_t; st = it.x_t;  end
            2'd2:    begin ct = -it.x_t; st = -it.y_t; end
            default: begin ct = it.y_t;  st = -it.x_t; end
        endcase
        o.prod_x = ct * sp;
        o.prod_z = st * sp;
        o.ny = to_normal(64'(cp), 30 - FRAC_BITS);
        return o;
    endfunction

    function automatic item_t finish(item_t it);
        item_t o;
        o = it;
        o.nx = to_normal(it.prod_x, 60 - FRAC_BITS);
        o.nz = to_normal(it.prod_z, 60 - FRAC_BITS);
        return o;
    endfunction

endpackage

// File: rtl/uvs_flow_ctrl.sv
module uvs_flow_ctrl
    import uvs_pkg::*;
(
    input  logic [NSTAGES-1:0] stage_valid,
    input  logic               out_ready,
    output logic [NSTAGES-1:0] advance
);

    // A stage may load unless it and every stage after it are full and the
    // receiver holds off.
    always_comb
    begin
        logic [NSTAGES-1:0] low;
        low = '0;
        for (int i = 0; i < NSTAGES; i++)
        begin
            advance[i] = out_ready || ((stage_valid | low) != {NSTAGES{1'b1}});
            low[i]     = 1'b1;
        end
    end

endmodule

// File: rtl/uv_sphere_vertex_generator.sv
// UV sphere vertex generator.
//
// Request channel: ring and segment with in_valid / in_ready. Result channel:
// normal_x/y/z (Q1.15), tex_u/tex_v (Q1.16), corner_a..d and quad_valid with
// out_valid / out_ready. Each request gives exactly one result, in order.
// Configuration: write cfg_data to register cfg_index (0 stack_count,
// 1 slice_count) with cfg_we high; both reset to 20. Each request snapshots
// the counts on entry, so a later write never disturbs requests in flight.
//
// The pipeline has 26 register stages: input capture and clamp, 11 stages of
// restoring division (3 quotient bits each) for both angle phases, 12 CORDIC
// stages (2 rotations each), quadrant fix-up with the normal products, and a
// round/saturate stage that is also the output register. One request is taken
// per cycle unless every stage is full and the receiver stalls.
//
// Reset clears all stage valid bits and restores the counts. When the
// receiver stalls, the pipeline keeps filling its empty stages and drops
// in_ready only once every stage holds a request.
module uv_sphere_vertex_generator
    import uvs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [COUNT_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COUNT_BITS-1:0] ring,
    input  logic [COUNT_BITS-1:0] segment,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [15:0]    normal_x,
    output logic signed [15:0]    normal_y,
    output logic signed [15:0]    normal_z,
    output logic [16:0]           tex_u,
    output logic [16:0]           tex_v,
    output logic [15:0]           corner_a,
    output logic [15:0]           corner_b,
    output logic [15:0]           corner_c,
    output logic [15:0]           corner_d,
    output logic                  quad_valid
);

    logic [COUNT_BITS-1:0] stack_count_reg;
    logic [COUNT_BITS-1:0] slice_count_reg;
    logic [NSTAGES-1:0]    valid_reg;
    logic [NSTAGES-1:0]    valid_next;
    logic [NSTAGES-1:0]    advance;
    item_t                 pipe_reg   [NSTAGES];
    item_t                 stage_next [NSTAGES];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= COUNT_BITS'(20);
            slice_count_reg <= COUNT_BITS'(20);
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_STACK_COUNT: stack_count_reg <= cfg_data;
                REG_SLICE_COUNT: slice_count_reg <= cfg_data;
                default:         stack_count_reg <= stack_count_reg;
            endcase
        end
    end

    uvs_flow_ctrl u_flow (
        .stage_valid (valid_reg),
        .out_ready   (out_ready),
        .advance     (advance)
    );

    // Advance valid bits where a stage loads; hold them elsewhere.
    assign valid_next = (advance & {valid_reg[NSTAGES-2:0], in_valid}) | (~advance & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    for (genvar g = 0; g < NSTAGES; g++)
    begin : g_stage
        if (g == 0)
        begin : g_capture
            assign stage_next[g] = capture(ring, segment, stack_count_reg, slice_count_reg);
        end
        else if (g == 1)
        begin : g_div_first
            assign stage_next[g] = div_stage(corner_calc(pipe_reg[g-1]), g);
        end
        else if (g <= DIV_STAGES)
        begin : g_div
            assign stage_next[g] = div_stage(pipe_reg[g-1], g);
        end
        else if (g == DIV_STAGES + 1)
        begin : g_cordic_first
            assign stage_next[g] = cordic_stage(cordic_init(pipe_reg[g-1]), 0);
        end
        else if (g < ROT_STAGE)
        begin : g_cordic
            assign stage_next[g] =
                cordic_stage(pipe_reg[g-1], CORDIC_PER_STAGE * (g - DIV_STAGES - 1));
        end
        else if (g == ROT_STAGE)
        begin : g_rotate
            assign stage_next[g] = rotate_mul(pipe_reg[g-1]);
        end
        else
        begin : g_finish
            assign stage_next[g] = finish(pipe_reg[g-1]);
        end

        always_ff @(posedge clk)
        begin
            if (advance[g])
                pipe_reg[g] <= stage_next[g];
        end
    end

    assign in_ready   = advance[0];
    assign out_valid  = valid_reg[LAST_STAGE];
    assign normal_x   = pipe_reg[LAST_STAGE].nx;
    assign normal_y   = pipe_reg[LAST_STAGE].ny;
    assign normal_z   = pipe_reg[LAST_STAGE].nz;
    assign tex_u      = pipe_reg[LAST_STAGE].tex_u;
    assign tex_v      = pipe_reg[LAST_STAGE].tex_v;
    assign corner_a   = pipe_reg[LAST_STAGE].ca;
    assign corner_b   = pipe_reg[LAST_STAGE].cb;
    assign corner_c   = pipe_reg[LAST_STAGE].cc;
    assign corner_d   = pipe_reg[LAST_STAGE].cd;
    assign quad_valid = pipe_reg[LAST_STAGE].qv;

    a_quad_corners: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && quad_valid |->
            corner_d == corner_a + 16'd1 && corner_c == corner_b + 16'd1)
        else $error("quad corners inconsistent");

    a_no_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !quad_valid |->
            corner_a == '0 && corner_b == '0 && corner_c == '0 && corner_d == '0)
        else $error("corners not cleared without quad");

    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tex_u <= 17'd65536 && tex_v <= 17'd65536)
        else $error("texture coordinate above one");

endmodule
